// ===== sv/dnsae_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS answer address extractor package
// Item types, parse phase codes and reset values shared by the extractor.
// ----------------------------------------------------------------------------
package dnsae_pkg;

	// Parse phase codes
	localparam logic [2:0] PH_QNAME = 3'd0;
	localparam logic [2:0] PH_QTAIL = 3'd1;
	localparam logic [2:0] PH_HDR   = 3'd2;
	localparam logic [2:0] PH_ADDR  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;

	// Result kinds
	localparam logic KIND_ADDR    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Fixed message layout
	localparam logic [15:0] QTAIL_LEN  = 16'd4;
	localparam logic [15:0] RR_HDR_LEN = 16'd12;
	localparam logic [15:0] IPV4_LEN   = 16'd4;
	localparam logic [15:0] RR_TYPE_A  = 16'd1;

	localparam logic [6:0] ADDR_LIMIT_RESET = 7'd100;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic        last_byte;
		logic [15:0] answer_count;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] address;
		logic [6:0]  address_index;
		logic        found_any;
		logic        last_of_run;
	} out_item_t;

	// Results produced by one parse step
	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} core_out_t;

	typedef struct packed {
		logic [2:0]  parse_phase;
		logic [15:0] phase_byte_count;
		logic [15:0] record_kind;
		logic [15:0] record_data_length;
		logic [31:0] address_gather;
		logic [15:0] records_seen;
		logic [15:0] expected_records;
		logic [6:0]  addresses_found;
		logic        parse_stopped;
	} parse_state_t;

	localparam parse_state_t PARSE_CLEAR = '{
		parse_phase:        PH_QNAME,
		phase_byte_count:   16'd0,
		record_kind:        16'd0,
		record_data_length: 16'd0,
		address_gather:     32'd0,
		records_seen:       16'd0,
		expected_records:   16'd0,
		addresses_found:    7'd0,
		parse_stopped:      1'b0
	};

endpackage

// ===== sv/dnsae_core.sv =====
// ----------------------------------------------------------------------------
// DNS answer address extractor parse core
// Holds the parse state and advances it by one message byte per step.
// ----------------------------------------------------------------------------
module dnsae_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  dnsae_pkg::in_item_t  item,
	input  logic [6:0]           limit,
	output dnsae_pkg::core_out_t rsp
);
	import dnsae_pkg::*;

	parse_state_t cur_q;
	parse_state_t nxt;
	logic         addr_hit;
	out_item_t    addr_res;
	out_item_t    sum_res;

	// Close a record: stop after the last expected one, else await a header.
	function automatic parse_state_t end_record(parse_state_t s);
		parse_state_t r;
		r = s;
		r.phase_byte_count = 16'd0;
		if (r.records_seen >= r.expected_records) begin
			r.parse_stopped = 1'b1;
		end else begin
			r.parse_phase = PH_HDR;
		end
		return r;
	endfunction

	always_comb begin
		nxt      = cur_q;
		addr_hit = 1'b0;
		addr_res = '0;
		if (item.first_byte) begin
			nxt                  = PARSE_CLEAR;
			nxt.expected_records = item.answer_count;
		end
		if (!nxt.parse_stopped) begin
			unique case (nxt.parse_phase)
				PH_QNAME: begin
					if (item.data_byte == 8'd0) begin
						nxt.parse_phase      = PH_QTAIL;
						nxt.phase_byte_count = 16'd0;
					end
				end
				PH_QTAIL: begin
					nxt.phase_byte_count = nxt.phase_byte_count + 16'd1;
					if (nxt.phase_byte_count >= QTAIL_LEN) begin
						nxt = end_record(nxt);
					end
				end
				PH_HDR: begin
					if (nxt.phase_byte_count == 16'd2) begin
						nxt.record_kind = {item.data_byte, 8'd0};
					end
					if (nxt.phase_byte_count == 16'd3) begin
						nxt.record_kind[7:0] = item.data_byte;
					end
					if (nxt.phase_byte_count == 16'd10) begin
						nxt.record_data_length = {item.data_byte, 8'd0};
					end
					if (nxt.phase_byte_count == 16'd11) begin
						nxt.record_data_length[7:0] = item.data_byte;
					end
					nxt.phase_byte_count = nxt.phase_byte_count + 16'd1;
					if (nxt.phase_byte_count >= RR_HDR_LEN) begin
						nxt.phase_byte_count = 16'd0;
						nxt.records_seen     = nxt.records_seen + 16'd1;
						if (nxt.record_kind == RR_TYPE_A) begin
							nxt.parse_phase    = PH_ADDR;
							nxt.address_gather = 32'd0;
						end else if (nxt.record_data_length == 16'd0) begin
							nxt = end_record(nxt);
						end else begin
							nxt.parse_phase      = PH_DATA;
							nxt.phase_byte_count = nxt.record_data_length;
						end
					end
				end
				PH_ADDR: begin
					nxt.address_gather   = {nxt.address_gather[23:0], item.data_byte};
					nxt.phase_byte_count = nxt.phase_byte_count + 16'd1;
					if (nxt.phase_byte_count >= IPV4_LEN) begin
						nxt.addresses_found       = nxt.addresses_found + 7'd1;
						addr_hit                  = 1'b1;
						addr_res.result_kind      = KIND_ADDR;
						addr_res.address          = nxt.address_gather;
						addr_res.address_index    = nxt.addresses_found;
						addr_res.found_any        = (nxt.addresses_found != 7'd0);
						nxt.phase_byte_count      = 16'd0;
						if (nxt.addresses_found >= limit) begin
							nxt.parse_stopped = 1'b1;
						end else if (nxt.record_data_length > IPV4_LEN) begin
							nxt.parse_phase      = PH_DATA;
							nxt.phase_byte_count = nxt.record_data_length - IPV4_LEN;
						end else begin
							nxt = end_record(nxt);
						end
					end
				end
				PH_DATA: begin
					if (nxt.phase_byte_count != 16'd0) begin
						nxt.phase_byte_count = nxt.phase_byte_count - 16'd1;
					end
					if (nxt.phase_byte_count == 16'd0) begin
						nxt = end_record(nxt);
					end
				end
				default: begin
					nxt.parse_stopped = 1'b1;
				end
			endcase
		end
		if (item.last_byte) begin
			nxt.parse_stopped = 1'b1;
		end
	end

	// Summary carries the counts after this byte
	always_comb begin
		sum_res               = '0;
		sum_res.result_kind   = KIND_SUMMARY;
		sum_res.address_index = nxt.addresses_found;
		sum_res.found_any     = (nxt.addresses_found != 7'd0);
		sum_res.last_of_run   = 1'b1;
	end

	// Order the results: address first, summary after it
	always_comb begin
		rsp = '0;
		priority if (addr_hit && item.last_byte) begin
			rsp.count  = 2'd2;
			rsp.first  = addr_res;
			rsp.second = sum_res;
		end else if (addr_hit) begin
			rsp.count             = 2'd1;
			rsp.first             = addr_res;
			rsp.first.last_of_run = 1'b1;
		end else if (item.last_byte) begin
			rsp.count = 2'd1;
			rsp.first = sum_res;
		end else begin
			rsp.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= PARSE_CLEAR;
		end else if (step) begin
			cur_q <= nxt;
		end
	end

endmodule

// ===== sv/dns_answer_address_extractor_unit.sv =====
// ----------------------------------------------------------------------------
// DNS answer address extractor
// Walks the answer section of a DNS message and reports IPv4 addresses.
// ----------------------------------------------------------------------------
// Feed the bytes that follow the 12-byte DNS header, one item per byte, with
// first_byte on the opening byte (answer_count is sampled there) and
// last_byte on the closing one. The block skips the question name and its
// type and class, then walks answer records assuming a 2-byte compressed
// name; each type 1 record yields one address item carrying the address in
// network order and its 1-based number. The last byte also yields a summary
// item with the total found. Records cut short by the end of the message
// yield nothing, and parsing stops after answer_count records or once
// address_limit addresses have been reported. Throughput is one byte per
// clock while results are not stalled; a byte that completes an address
// and also ends the message makes two result items, and since the result
// register delivers one item per cycle, such a byte holds the input until
// the second item is taken. A byte accepted sits in the input register
// until the core steps on it, which loads its first result item into the
// result register, whose head drives the result port. A stalled result
// item holds the core: the input register takes at most one more byte,
// then the input stalls until the head result item is taken and no second
// one waits behind it. address_limit resets to 100 and may be written only
// while no message is in flight; cfg_ready is always high.
// ----------------------------------------------------------------------------
module dns_answer_address_extractor_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	// byte items
	input  logic                 item_valid,
	output logic                 item_stall,
	input  dnsae_pkg::in_item_t  item,
	// result items
	output logic                 result_valid,
	input  logic                 result_stall,
	output dnsae_pkg::out_item_t result,
	// address_limit register
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [6:0]           cfg_data
);
	import dnsae_pkg::*;

	logic [6:0] limit_q;

	in_item_t   item_s1;
	logic       valid_s1;

	out_item_t  res0_q;
	out_item_t  res1_q;
	logic [1:0] res_cnt_q;

	logic       pop;
	logic       core_step;
	logic       accept;
	core_out_t  core_rsp;

	// Configuration: single register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= ADDR_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Handshakes
	assign pop          = result_valid && !result_stall;
	assign result_valid = (res_cnt_q != 2'd0);
	assign result       = res0_q;

	// Step the core only when its results land in an empty result register
	assign core_step  = valid_s1 && ((res_cnt_q == 2'd0) || ((res_cnt_q == 2'd1) && pop));
	assign item_stall = valid_s1 && !core_step;
	assign accept     = item_valid && !item_stall;

	// Input register: hold the byte until the core steps on it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (core_step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	dnsae_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (core_step),
		.item   (item_s1),
		.limit  (limit_q),
		.rsp    (core_rsp)
	);

	// Result register: up to two items, head drives the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_cnt_q <= 2'd0;
		end else if (core_step) begin
			res_cnt_q <= core_rsp.count;
		end else if (pop) begin
			res_cnt_q <= res_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (core_step) begin
			res0_q <= core_rsp.first;
			res1_q <= core_rsp.second;
		end else if (pop) begin
			// advance the second item to the head
			res0_q <= res1_q;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q != 2'd3)
		else $error("result count out of range");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q == 2'd2 |-> res0_q.result_kind == KIND_ADDR && !res0_q.last_of_run
			&& res1_q.result_kind == KIND_SUMMARY && res1_q.last_of_run)
		else $error("address and summary pair out of order");

	a_hold_item: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !core_step |=> valid_s1 && $stable(item_s1))
		else $error("waiting item lost");

	a_empty_step: assert property (@(posedge clk) disable iff (!arst_n)
		core_step && core_rsp.count == 2'd0 |=> !result_valid)
		else $error("result shown for a byte that made none");

	a_addr_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.result_kind == KIND_ADDR |-> result.found_any
			&& result.address_index != 7'd0)
		else $error("address item without a count");
`endif

endmodule
